@@ rtl/ilac_pkg.sv @@
// ----------------------------------------------------------------------------
// ilac_pkg
// Shared widths, register map, micro-op encodings and control structs for the
// IMU lever-arm compensation block.
// ----------------------------------------------------------------------------
package ilac_pkg;

    localparam int TsW    = 48;   // timestamp
    localparam int VecW   = 24;   // vector components
    localparam int DtW    = TsW + 1;
    localparam int LimW   = 20;   // dt limit and divisor
    localparam int RegW   = 48;
    localparam int EntW   = 16;   // matrix entries and lever arm components
    localparam int AccW   = 64;
    localparam int AW     = 34;   // multiplier operand A
    localparam int BW     = 26;   // multiplier operand B
    localparam int PW     = AW + BW;
    localparam int MagW   = 42;   // magnitude of the angular cross product
    localparam int HalfW  = MagW / 2;
    localparam int CrW    = 33;   // rounded centripetal cross product
    localparam int AbW    = 48;   // corrected acceleration before saturation
    localparam int NumW   = 47;   // dividend and quotient
    localparam int OutDtW = 32;
    localparam int ApbDW  = 64;
    localparam int ApbAW  = 6;
    localparam int InW    = 192;
    localparam int OutW   = 176;

    localparam logic [BW-1:0]   MEGA        = BW'(1000000);
    localparam logic [RegW-1:0] ROT0_RESET  = 48'h4000_0000_0000;
    localparam logic [RegW-1:0] ROT1_RESET  = 48'h0000_4000_0000;
    localparam logic [RegW-1:0] ROT2_RESET  = 48'h0000_0000_4000;
    localparam logic [LimW-1:0] LIMIT_RESET = LimW'(100000);

    typedef enum logic [2:0] {
        REG_ROT0, REG_ROT1, REG_ROT2, REG_LEVER, REG_LIMIT
    } t_reg_idx;

    typedef enum logic [2:0] {A_ROT, A_D, A_WB, A_CR, A_MHI, A_MLO} t_asel;
    typedef enum logic [2:0] {B_G, B_A, B_R, B_WB, B_MEGA} t_bsel;
    typedef enum logic [2:0] {ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_LOAD_HI} t_accop;
    typedef enum logic [2:0] {ST_NONE, ST_WB, ST_AB, ST_CX, ST_C, ST_CC, ST_NUM} t_stop;

    typedef struct packed {
        t_asel      asel;
        logic [1:0] a_idx;
        t_bsel      bsel;
        logic [1:0] b_idx;
        t_accop     accop;
        t_stop      stop;
        logic [1:0] st_idx;
    } t_mcmd;

    typedef struct packed {
        t_mcmd      mop;
        logic       seed;
        logic       fin;
        logic       div_start;
        logic       qadd;
        logic [1:0] q_idx;
    } t_cmd;

    typedef struct packed {
        logic applied;
        logic have_prev;
        logic out_free;
        logic div_busy;
    } t_stat;

    localparam t_mcmd MOP_NOP = '{A_ROT, 2'd0, B_G, 2'd0, ACC_NONE, ST_NONE, 2'd0};

endpackage

@@ rtl/ilac_regs.sv @@
// ----------------------------------------------------------------------------
// ilac_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module ilac_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ilac_pkg::ApbAW-1:0]  paddr,
    input  logic [ilac_pkg::ApbDW-1:0]  pwdata,
    output logic [ilac_pkg::ApbDW-1:0]  prdata,
    output logic                        pready,
    output logic [2:0][ilac_pkg::RegW-1:0] o_rot,
    output logic [ilac_pkg::RegW-1:0]   o_lever,
    output logic [ilac_pkg::LimW-1:0]   o_limit
);
    import ilac_pkg::*;

    logic [2:0][RegW-1:0] r_rot;
    logic [RegW-1:0]      r_lever;
    logic [LimW-1:0]      r_limit;
    t_reg_idx             w_idx;

    assign w_idx  = t_reg_idx'(paddr[ApbAW-1:3]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0] <= ROT0_RESET;
            r_rot[1] <= ROT1_RESET;
            r_rot[2] <= ROT2_RESET;
            r_lever  <= '0;
            r_limit  <= LIMIT_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_ROT0:  r_rot[0] <= pwdata[RegW-1:0];
                REG_ROT1:  r_rot[1] <= pwdata[RegW-1:0];
                REG_ROT2:  r_rot[2] <= pwdata[RegW-1:0];
                REG_LEVER: r_lever  <= pwdata[RegW-1:0];
                REG_LIMIT: r_limit  <= pwdata[LimW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ROT0:  prdata = ApbDW'(r_rot[0]);
            REG_ROT1:  prdata = ApbDW'(r_rot[1]);
            REG_ROT2:  prdata = ApbDW'(r_rot[2]);
            REG_LEVER: prdata = ApbDW'(r_lever);
            REG_LIMIT: prdata = ApbDW'(r_limit);
            default:   prdata = '0;
        endcase
    end

    assign o_rot   = r_rot;
    assign o_lever = r_lever;
    assign o_limit = r_limit;

endmodule

@@ rtl/ilac_div.sv @@
// ----------------------------------------------------------------------------
// ilac_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ilac_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ilac_pkg::NumW-1:0]  i_num,
    input  logic [ilac_pkg::LimW-1:0]  i_den,
    output logic                       o_busy,
    output logic [ilac_pkg::NumW-1:0]  o_quo
);
    import ilac_pkg::*;

    localparam int CntW = $clog2(NumW);

    logic            r_busy;
    logic [CntW-1:0] r_cnt;
    logic [LimW-1:0] r_rem;
    logic [NumW-1:0] r_quo;
    logic [LimW:0]   w_shift;
    logic [LimW+1:0] w_trial;
    logic            w_ge;

    assign w_shift = {r_rem, r_quo[NumW-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, i_den};
    assign w_ge    = !w_trial[LimW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_cnt == CntW'(NumW - 1))) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= w_ge ? w_trial[LimW-1:0] : w_shift[LimW-1:0];
            r_quo <= {r_quo[NumW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

@@ rtl/ilac_ctrl.sv @@
// ----------------------------------------------------------------------------
// ilac_ctrl
// Sequencer: in its multiply states it issues one micro-op per cycle to the
// datapath; it also steps the divider for each axis.
// ----------------------------------------------------------------------------
module ilac_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  ilac_pkg::t_stat  i_stat,
    output logic             o_ready,
    output ilac_pkg::t_cmd   o_cmd
);
    import ilac_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_ROT   = 11'b00000000010,
        S_CX    = 11'b00000000100,
        S_C     = 11'b00000001000,
        S_GAP   = 11'b00000010000,
        S_CC    = 11'b00000100000,
        S_MEGA  = 11'b00001000000,
        S_DRAIN = 11'b00010000000,
        S_DIV   = 11'b00100000000,
        S_DWAIT = 11'b01000000000,
        S_FIN   = 11'b10000000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_i, n_i;
    logic       r_h, n_h;
    logic       r_j, n_j;
    logic [1:0] r_k, n_k;
    logic [1:0] r_row;
    logic [1:0] w_k1, w_k2;

    function automatic logic [1:0] f_inc3(input logic [1:0] v);
        return (v == 2'd2) ? 2'd0 : v + 2'd1;
    endfunction

    assign w_k1 = f_inc3(r_k);
    assign w_k2 = f_inc3(w_k1);
    assign r_row = r_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_h     <= 1'b0;
            r_j     <= 1'b0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_h     <= n_h;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    // Column counter for the matrix rows runs 0..2 in r_k during S_ROT.
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_h     = r_h;
        n_j     = r_j;
        n_k     = r_k;
        o_cmd           = '0;
        o_cmd.mop       = MOP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_state = S_ROT;
                    n_i     = '0;
                    n_h     = 1'b0;
                    n_k     = '0;
                end
            end
            S_ROT: begin
                o_cmd.mop.asel   = A_ROT;
                o_cmd.mop.a_idx  = r_row;
                o_cmd.mop.bsel   = r_h ? B_A : B_G;
                o_cmd.mop.b_idx  = r_k;
                o_cmd.mop.accop  = (r_k == 2'd0) ? ACC_LOAD : ACC_ADD;
                o_cmd.mop.st_idx = r_row;
                if (r_k == 2'd2) begin
                    o_cmd.mop.stop = r_h ? ST_AB : ST_WB;
                    n_k = '0;
                    n_h = !r_h;
                    if (r_h) begin
                        if (r_i == 2'd2) begin
                            n_j     = 1'b0;
                            n_state = i_stat.applied ? S_CX : S_DRAIN;
                        end else begin
                            n_i = r_i + 2'd1;
                        end
                    end
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_CX, S_C, S_CC: begin
                // cross product: first term LOAD, second term SUB and store
                o_cmd.mop.a_idx  = r_j ? w_k2 : w_k1;
                o_cmd.mop.b_idx  = r_j ? w_k1 : w_k2;
                o_cmd.mop.accop  = r_j ? ACC_SUB : ACC_LOAD;
                o_cmd.mop.st_idx = r_k;
                if (r_state == S_CX) begin
                    o_cmd.mop.asel = A_D;
                    o_cmd.mop.bsel = B_R;
                    o_cmd.mop.stop = r_j ? ST_CX : ST_NONE;
                end else if (r_state == S_C) begin
                    o_cmd.mop.asel = A_WB;
                    o_cmd.mop.bsel = B_R;
                    o_cmd.mop.stop = r_j ? ST_C : ST_NONE;
                end else begin
                    // rate x cr: A carries cr, so swap the index roles
                    o_cmd.mop.asel  = A_CR;
                    o_cmd.mop.bsel  = B_WB;
                    o_cmd.mop.a_idx = r_j ? w_k1 : w_k2;
                    o_cmd.mop.b_idx = r_j ? w_k2 : w_k1;
                    o_cmd.mop.stop  = r_j ? ST_CC : ST_NONE;
                end
                n_j = !r_j;
                if (r_j) begin
                    if (r_k == 2'd2) begin
                        n_k = '0;
                        if (r_state == S_CX) begin
                            n_state = S_C;
                        end else if (r_state == S_C) begin
                            n_state = S_GAP;
                        end else begin
                            n_state = S_MEGA;
                        end
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end
            end
            S_GAP: begin
                // hold until the rounded centripetal terms are stored
                n_j = !r_j;
                if (r_j) begin
                    n_state = S_CC;
                end
            end
            S_MEGA: begin
                o_cmd.mop.asel   = r_j ? A_MLO : A_MHI;
                o_cmd.mop.a_idx  = r_k;
                o_cmd.mop.bsel   = B_MEGA;
                o_cmd.mop.accop  = r_j ? ACC_ADD : ACC_LOAD_HI;
                o_cmd.mop.stop   = r_j ? ST_NUM : ST_NONE;
                o_cmd.mop.st_idx = r_k;
                n_j = !r_j;
                if (r_j) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_j = !r_j;
                if (r_j) begin
                    n_state = i_stat.applied ? S_DIV : S_FIN;
                end
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.qadd  = 1'b1;
                    o_cmd.q_idx = r_k;
                    if (r_k == 2'd2) begin
                        n_state = S_FIN;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_j     = 1'b0;
                        n_state = S_MEGA;
                    end
                end
            end
            S_FIN: begin
                if (!i_stat.have_prev) begin
                    o_cmd.seed = 1'b1;
                    n_state    = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

@@ rtl/ilac_dp.sv @@
// ----------------------------------------------------------------------------
// ilac_dp
// Datapath: one shared multiplier, a 64-bit accumulator, vector stores,
// sample state and the output register.
// ----------------------------------------------------------------------------
module ilac_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [ilac_pkg::InW-1:0]       i_in_data,
    input  ilac_pkg::t_cmd                 i_cmd,
    input  logic [2:0][ilac_pkg::RegW-1:0] i_rot,
    input  logic [ilac_pkg::RegW-1:0]      i_lever,
    input  logic [ilac_pkg::LimW-1:0]      i_limit,
    input  logic                           i_out_ready,
    input  logic                           i_div_busy,
    input  logic [ilac_pkg::NumW-1:0]      i_quo,
    output logic [ilac_pkg::NumW-1:0]      o_num,
    output logic [ilac_pkg::LimW-1:0]      o_den,
    output ilac_pkg::t_stat                o_stat,
    output logic                           o_out_valid,
    output logic [ilac_pkg::OutW-1:0]      o_out_data,
    output logic                           o_out_flag
);
    import ilac_pkg::*;

    localparam longint VMax = (64'sd1 <<< (VecW - 1)) - 1;
    localparam longint VMin = -VMax - 1;
    localparam longint DMax = (64'sd1 <<< (OutDtW - 1)) - 1;
    localparam longint DMin = -DMax - 1;

    logic [TsW-1:0]          r_ts, r_last;
    logic signed [VecW-1:0]  r_g [3];
    logic signed [VecW-1:0]  r_a [3];
    logic signed [VecW-1:0]  r_wb [3];
    logic signed [VecW-1:0]  r_prev [3];
    logic signed [AbW-1:0]   r_ab [3];
    logic signed [CrW-1:0]   r_cr [3];
    logic [MagW-1:0]         r_mag [3];
    logic                    r_neg [3];
    logic signed [DtW-1:0]   r_dt;
    logic                    r_have;
    logic [NumW-1:0]         r_num;
    logic signed [PW-1:0]    r_p;
    logic signed [AccW-1:0]  r_acc;
    t_mcmd                   r_c1, r_c2;
    logic                    r_out_valid;
    logic [OutW-1:0]         r_out_data;
    logic                    r_out_flag;

    logic signed [EntW-1:0]  w_e, w_r;
    logic signed [VecW:0]    w_d;
    logic signed [AW-1:0]    w_a;
    logic signed [BW-1:0]    w_b;
    logic signed [PW-1:0]    w_prod;
    logic signed [AccW-1:0]  w_pext, w_r14, w_r8, w_r24;
    logic [AccW-1:0]         w_abs, w_numsum;
    logic signed [AbW-1:0]   w_q, w_qs;
    logic                    w_applied;
    logic [OutDtW-1:0]       w_dt32;
    logic [VecW-1:0]         w_accsat [3];

    function automatic logic [VecW-1:0] f_sat(input logic signed [AccW-1:0] v);
        if (v > VMax) return VecW'(VMax);
        if (v < VMin) return VecW'(VMin);
        return v[VecW-1:0];
    endfunction

    // operand A
    always_comb begin
        w_e = i_rot[i_cmd.mop.a_idx][EntW*i_cmd.mop.b_idx +: EntW];
        w_d = (VecW+1)'(r_wb[i_cmd.mop.a_idx]) - (VecW+1)'(r_prev[i_cmd.mop.a_idx]);
        unique case (i_cmd.mop.asel)
            A_ROT:   w_a = AW'(w_e);
            A_D:     w_a = AW'(w_d);
            A_WB:    w_a = AW'(r_wb[i_cmd.mop.a_idx]);
            A_CR:    w_a = AW'(r_cr[i_cmd.mop.a_idx]);
            A_MHI:   w_a = AW'(r_mag[i_cmd.mop.a_idx][MagW-1:HalfW]);
            A_MLO:   w_a = AW'(r_mag[i_cmd.mop.a_idx][HalfW-1:0]);
            default: w_a = '0;
        endcase
    end

    // operand B
    always_comb begin
        w_r = i_lever[EntW*i_cmd.mop.b_idx +: EntW];
        unique case (i_cmd.mop.bsel)
            B_G:     w_b = BW'(r_g[i_cmd.mop.b_idx]);
            B_A:     w_b = BW'(r_a[i_cmd.mop.b_idx]);
            B_R:     w_b = BW'(w_r);
            B_WB:    w_b = BW'(r_wb[i_cmd.mop.b_idx]);
            B_MEGA:  w_b = signed'(MEGA);
            default: w_b = '0;
        endcase
    end

    assign w_prod   = w_a * w_b;
    assign w_pext   = AccW'(r_p);
    assign w_r14    = r_acc + (64'sd1 <<< 13);
    assign w_r8     = r_acc + (64'sd1 <<< 7);
    assign w_r24    = r_acc + (64'sd1 <<< 23);
    assign w_abs    = r_acc[AccW-1] ? unsigned'(-r_acc) : unsigned'(r_acc);
    assign w_numsum = unsigned'(r_acc) + {29'd0, r_dt[LimW-1:0], 15'd0};
    assign w_q      = signed'({1'b0, i_quo});
    assign w_qs     = r_neg[i_cmd.q_idx] ? -w_q : w_q;

    assign w_applied = r_have && !r_dt[DtW-1] && (r_dt != '0)
                       && (r_dt[TsW-1:0] < TsW'(i_limit));

    always_comb begin
        if (r_dt > DMax) begin
            w_dt32 = OutDtW'(DMax);
        end else if (r_dt < DMin) begin
            w_dt32 = OutDtW'(DMin);
        end else begin
            w_dt32 = r_dt[OutDtW-1:0];
        end
        for (int i = 0; i < 3; i++) begin
            w_accsat[i] = f_sat(AccW'(r_ab[i]));
        end
    end

    // input capture and time step
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_ts <= i_in_data[TsW-1:0];
            for (int i = 0; i < 3; i++) begin
                r_g[i] <= i_in_data[TsW + VecW*i +: VecW];
                r_a[i] <= i_in_data[TsW + VecW*(3+i) +: VecW];
            end
            r_dt <= signed'({1'b0, i_in_data[TsW-1:0]}) - signed'({1'b0, r_last});
        end
    end

    // multiply, accumulate, store: a micro-op advances one stage a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= MOP_NOP;
            r_c2 <= MOP_NOP;
        end else begin
            r_c1 <= i_cmd.mop;
            r_c2 <= r_c1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= w_prod;
        unique case (r_c1.accop)
            ACC_LOAD:    r_acc <= w_pext;
            ACC_ADD:     r_acc <= r_acc + w_pext;
            ACC_SUB:     r_acc <= r_acc - w_pext;
            ACC_LOAD_HI: r_acc <= w_pext <<< HalfW;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_c2.stop)
            ST_WB:  r_wb[r_c2.st_idx] <= f_sat(w_r14 >>> 14);
            ST_CX: begin
                r_neg[r_c2.st_idx] <= r_acc[AccW-1];
                r_mag[r_c2.st_idx] <= w_abs[MagW-1:0];
            end
            ST_C:   r_cr[r_c2.st_idx] <= CrW'(w_r8 >>> 8);
            ST_NUM: r_num <= w_numsum[NumW+15:16];
            default: ;
        endcase
    end

    // corrected acceleration: rotation, centripetal term, angular term
    always_ff @(posedge i_clk) begin
        if (r_c2.stop == ST_AB) begin
            r_ab[r_c2.st_idx] <= AbW'(w_r14 >>> 14);
        end else if (r_c2.stop == ST_CC) begin
            r_ab[r_c2.st_idx] <= r_ab[r_c2.st_idx] + AbW'(w_r24 >>> 24);
        end else if (i_cmd.qadd) begin
            r_ab[i_cmd.q_idx] <= r_ab[i_cmd.q_idx] + w_qs;
        end
    end

    // sample state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_last <= '0;
            for (int i = 0; i < 3; i++) begin
                r_prev[i] <= '0;
            end
        end else if (i_cmd.seed || i_cmd.fin) begin
            r_have <= 1'b1;
            r_last <= r_ts;
            for (int i = 0; i < 3; i++) begin
                r_prev[i] <= r_wb[i];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out_data <= {w_dt32, w_accsat[2], w_accsat[1], w_accsat[0],
                           r_wb[2], r_wb[1], r_wb[0]};
            r_out_flag <= w_applied;
        end
    end

    assign o_num  = r_num;
    assign o_den  = r_dt[LimW-1:0];
    assign o_stat = '{applied:   w_applied,
                      have_prev: r_have,
                      out_free:  !r_out_valid || i_out_ready,
                      div_busy:  i_div_busy};
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_flag  = r_out_flag;

endmodule

@@ rtl/imu_lever_arm_compensation.sv @@
// ----------------------------------------------------------------------------
// imu_lever_arm_compensation
// Rotates IMU gyro and accel words into the body frame and adds the
// lever-arm correction to the acceleration.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample word per handshake; m_axis returns one result
//   word per sample, except for the first sample after reset, which only seeds
//   the stored timestamp and rate. m_axis_tuser flags that the lever-arm
//   correction was added (0 < time step < dt_limit_us).
//   Configuration goes through the APB-style port at byte addresses 8*i:
//   rot_row0, rot_row1, rot_row2, lever offset, dt_limit_us. Write it while idle.
// Sequence:
//   One shared multiplier works through both nine-product rotations; a sample
//   without correction then has its result written to the output register.
//   With correction the cross products follow, and each axis's angular term
//   runs a 47-step restoring divide before the result is written.
//   One sample is in work at a time; s_axis_tready is high only when idle.
// Reset and stall:
//   Reset restores the register defaults and clears the stored sample state.
//   A result waits in the output register while m_axis_tready is low; the next
//   sample is still taken and worked on, and holds only at its own result.
// ----------------------------------------------------------------------------
module imu_lever_arm_compensation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // s_axis_tdata, from bit 0 up: timestamp_us[48], gyro_x, gyro_y, gyro_z,
    // accel_x, accel_y, accel_z (24 each)
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ilac_pkg::InW-1:0]      s_axis_tdata,
    // m_axis_tdata, from bit 0 up: rate_body_x, rate_body_y, rate_body_z,
    // acc_body_x, acc_body_y, acc_body_z (24 each), time_step_us[32]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ilac_pkg::OutW-1:0]     m_axis_tdata,
    // m_axis_tuser: lever_applied
    output logic                          m_axis_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ilac_pkg::ApbAW-1:0]    paddr,
    input  logic [ilac_pkg::ApbDW-1:0]    pwdata,
    output logic [ilac_pkg::ApbDW-1:0]    prdata,
    output logic                          pready
);
    import ilac_pkg::*;

    logic                 w_accept;
    logic                 w_ready;
    t_cmd                 w_cmd;
    t_stat                w_stat;
    logic [2:0][RegW-1:0] w_rot;
    logic [RegW-1:0]      w_lever;
    logic [LimW-1:0]      w_limit;
    logic                 w_div_busy;
    logic [NumW-1:0]      w_quo, w_num;
    logic [LimW-1:0]      w_den;

    // accept a sample word on the input handshake
    assign s_axis_tready = w_ready;
    assign w_accept      = s_axis_tvalid && w_ready;

    ilac_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_rot   (w_rot),
        .o_lever (w_lever),
        .o_limit (w_limit)
    );

    ilac_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_stat   (w_stat),
        .o_ready  (w_ready),
        .o_cmd    (w_cmd)
    );

    ilac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    ilac_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .i_rot       (w_rot),
        .i_lever     (w_lever),
        .i_limit     (w_limit),
        .i_out_ready (m_axis_tready),
        .i_div_busy  (w_div_busy),
        .i_quo       (w_quo),
        .o_num       (w_num),
        .o_den       (w_den),
        .o_stat      (w_stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_flag  (m_axis_tuser)
    );

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IMU lever-arm compensation block: drives sample
// words on s_axis, predicts each result word in a scoreboard class and checks
// m_axis field by field while both sides stall at random in most phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ilac_pkg::*;

    // Shift right with rounding to nearest, ties toward plus infinity.
    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // Divide with ties away from zero.
    function automatic longint div_away(longint n, longint d);
        longint m;
        m = n < 0 ? -n : n;
        m = (m + d / 2) / d;
        return n < 0 ? -m : m;
    endfunction

    class ilac_scoreboard;
        logic [RegW-1:0] rot [3];
        logic [RegW-1:0] lever;
        logic [LimW-1:0] limit;
        logic [TsW-1:0]  prev_ts;
        bit              seeded;
        longint          prev_rate [3];
        logic [OutW:0]   pending [$];   // tuser on top of tdata
        int              errors;
        int              checked;
        int              applied_cnt;

        function new();
            rot[0] = ROT0_RESET; rot[1] = ROT1_RESET; rot[2] = ROT2_RESET;
            lever = '0; limit = LIMIT_RESET; seeded = 0;
            prev_ts = '0; prev_rate = '{0, 0, 0};
            errors = 0; checked = 0; applied_cnt = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [63:0] v);
            case (idx)
                REG_ROT0:  rot[0] = v[RegW-1:0];
                REG_ROT1:  rot[1] = v[RegW-1:0];
                REG_ROT2:  rot[2] = v[RegW-1:0];
                REG_LEVER: lever  = v[RegW-1:0];
                REG_LIMIT: limit  = v[LimW-1:0];
                default: ;
            endcase
        endfunction

        // Note an accepted sample word; queue its result if it makes one.
        function void note_sample(logic [InW-1:0] w);
            longint g [3], a [3], wb [3], ab [3], r [3], d [3];
            longint cx [3], c [3], cr [3], cc [3];
            longint sg, sa, e, dt;
            logic [TsW-1:0] ts;
            bit applied;
            logic [OutW:0] o;
            ts = w[TsW-1:0];
            for (int i = 0; i < 3; i++) begin
                g[i] = longint'($signed(w[TsW + VecW*i +: VecW]));
                a[i] = longint'($signed(w[TsW + VecW*(3+i) +: VecW]));
            end
            for (int i = 0; i < 3; i++) begin
                sg = 0; sa = 0;
                for (int j = 0; j < 3; j++) begin
                    e = longint'($signed(rot[i][EntW*j +: EntW]));
                    sg += e * g[j];
                    sa += e * a[j];
                end
                wb[i] = clamp(round_shift(sg, 14), VecW);
                ab[i] = round_shift(sa, 14);
            end
            if (!seeded) begin
                seeded = 1; prev_ts = ts;
                for (int i = 0; i < 3; i++) prev_rate[i] = wb[i];
                return;
            end
            dt = longint'({16'd0, ts}) - longint'({16'd0, prev_ts});
            prev_ts = ts;
            applied = dt > 0 && dt < longint'(limit);
            if (applied) begin
                for (int i = 0; i < 3; i++) begin
                    r[i] = longint'($signed(lever[EntW*i +: EntW]));
                    d[i] = wb[i] - prev_rate[i];
                end
                cx[0] = d[1]*r[2] - d[2]*r[1];
                cx[1] = d[2]*r[0] - d[0]*r[2];
                cx[2] = d[0]*r[1] - d[1]*r[0];
                c[0] = wb[1]*r[2] - wb[2]*r[1];
                c[1] = wb[2]*r[0] - wb[0]*r[2];
                c[2] = wb[0]*r[1] - wb[1]*r[0];
                for (int i = 0; i < 3; i++) cr[i] = round_shift(c[i], 8);
                cc[0] = wb[1]*cr[2] - wb[2]*cr[1];
                cc[1] = wb[2]*cr[0] - wb[0]*cr[2];
                cc[2] = wb[0]*cr[1] - wb[1]*cr[0];
                for (int i = 0; i < 3; i++)
                    ab[i] += div_away(cx[i] * 1000000, dt <<< 16) + round_shift(cc[i], 24);
            end
            for (int i = 0; i < 3; i++) prev_rate[i] = wb[i];
            o = '0;
            for (int i = 0; i < 3; i++) begin
                o[VecW*i +: VecW]     = wb[i][VecW-1:0];
                o[VecW*(3+i) +: VecW] = VecW'(clamp(ab[i], VecW));
            end
            o[6*VecW +: OutDtW] = OutDtW'(clamp(dt, OutDtW));
            o[OutW] = applied;
            pending.push_back(o);
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("MISMATCH word %0d %s: got %0d want %0d", checked, what, got, want);
        endtask

        task check_result(logic [OutW-1:0] data, logic user);
            logic [OutW:0] x;
            string nm [7] = '{"rate_x", "rate_y", "rate_z", "acc_x", "acc_y", "acc_z", "dt"};
            if (pending.size() == 0) begin
                report("unexpected word", 0, 0);
                return;
            end
            x = pending.pop_front();
            for (int i = 0; i < 6; i++)
                if (data[VecW*i +: VecW] !== x[VecW*i +: VecW])
                    report(nm[i], $signed(data[VecW*i +: VecW]), $signed(x[VecW*i +: VecW]));
            if (data[6*VecW +: OutDtW] !== x[6*VecW +: OutDtW])
                report(nm[6], $signed(data[6*VecW +: OutDtW]), $signed(x[6*VecW +: OutDtW]));
            if (user !== x[OutW]) report("lever_applied", user, x[OutW]);
            if (x[OutW]) applied_cnt++;
            checked++;
        endtask
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic s_axis_tvalid = 0, s_axis_tready;
    logic [InW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid, m_axis_tready = 0, m_axis_tuser;
    logic [OutW-1:0] m_axis_tdata;
    logic psel = 0, penable = 0, pwrite = 0, pready;
    logic [ApbAW-1:0] paddr = '0;
    logic [ApbDW-1:0] pwdata = '0, prdata;

    ilac_scoreboard sb = new();
    bit src_idle_on = 1, snk_idle_on = 1, hold_sink = 0;
    logic [TsW-1:0] now_ts = '0;

    imu_lever_arm_compensation u_top (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Write one register through the setup and access phases, then return the bus to idle.
    task automatic apb_write(t_reg_idx idx, logic [63:0] v);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= ApbAW'(8 * int'(idx)); pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, v);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
    endtask

    // Offer one sample word and hold it until the block takes it.
    task automatic send_sample(logic [InW-1:0] w);
        int gap;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1; s_axis_tdata <= w;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_sample(w);
    endtask

    function automatic logic [23:0] rnd_vec(int mode);
        case (mode)
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(0, 8191)) - 4096);
            default: return 24'($urandom);
        endcase
    endfunction

    // Assemble a sample: small rates usually, full range now and then.
    task automatic send_rand(int dt_mode);
        logic [InW-1:0] w;
        int m;
        case (dt_mode)
            0: now_ts = now_ts + TsW'($urandom_range(1, 3000));
            1: now_ts = now_ts;
            2: now_ts = now_ts - TsW'($urandom_range(1, 5000));
            3: now_ts = now_ts + TsW'($urandom_range(100000, 3000000));
            default: now_ts = TsW'({$urandom, $urandom});
        endcase
        w[TsW-1:0] = now_ts;
        for (int i = 0; i < 6; i++) begin
            m = $urandom_range(0, 9) < 7 ? 2 : $urandom_range(0, 3);
            w[TsW + VecW*i +: VecW] = rnd_vec(m);
        end
        send_sample(w);
    endtask

    // Drop the input valid and wait for every queued result.
    task automatic wait_drained();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    function automatic logic [47:0] rnd_row();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    // Sink: accept results, stalling in random bursts.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_sink) begin
                m_axis_tready <= 0;
                repeat (3000) @(posedge i_clk);
                hold_sink = 0;
            end else if (snk_idle_on && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 16);
                m_axis_tready <= 0;
                repeat (gap) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);

    initial begin
        logic [InW-1:0] w;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: seed, field extremes, zero and negative steps, long step.
        w = '0; send_sample(w);
        w[TsW-1:0] = 48'd100;
        for (int i = 0; i < 6; i++) w[TsW + VecW*i +: VecW] = 24'h7FFFFF;
        send_sample(w);
        for (int i = 0; i < 6; i++) w[TsW + VecW*i +: VecW] = 24'h800000;
        send_sample(w);                       // zero step
        w[TsW-1:0] = 48'd50; send_sample(w);  // negative step
        w[TsW-1:0] = 48'hFFFF_FFFF_FFFF; send_sample(w);
        w[TsW-1:0] = 48'd0; send_sample(w);
        wait_drained();

        // Lever arm and full-scale matrix, with correction.
        apb_write(REG_LEVER, 64'h7FFF_8000_7FFF);
        apb_write(REG_ROT0, 64'h7FFF_8000_4000);
        apb_write(REG_ROT1, 64'h8000_7FFF_C000);
        apb_write(REG_ROT2, 64'hFFFF_FFFF_FFFF);
        apb_write(REG_LIMIT, 64'hF_FFFF);
        now_ts = '0;
        w[TsW-1:0] = 48'd1;
        for (int i = 0; i < 6; i++) w[TsW + VecW*i +: VecW] = 24'h7FFFFF;
        send_sample(w);
        w[TsW-1:0] = 48'd2;
        for (int i = 0; i < 3; i++) w[TsW + VecW*i +: VecW] = 24'h800000;
        send_sample(w);
        now_ts = 48'd2;
        repeat (10) send_rand(0);
        wait_drained();

        // Random phases across several settings.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin apb_write(REG_LIMIT, 64'd1); end
                1: begin
                    apb_write(REG_ROT0, ROT0_RESET); apb_write(REG_ROT1, ROT1_RESET);
                    apb_write(REG_ROT2, ROT2_RESET); apb_write(REG_LIMIT, 64'd100000);
                    apb_write(REG_LEVER, {16'($urandom), 16'($urandom), 16'($urandom)});
                end
                2: begin
                    apb_write(REG_LEVER, 64'h8000_8000_8000);
                    apb_write(REG_LIMIT, 64'd1000000);
                end
                default: begin
                    apb_write(REG_ROT0, rnd_row()); apb_write(REG_ROT1, rnd_row());
                    apb_write(REG_ROT2, rnd_row()); apb_write(REG_LEVER, rnd_row());
                    apb_write(REG_LIMIT, 64'($urandom_range(1, 1000000)));
                end
            endcase
            if (ph == 4) hold_sink = 1;
            if (ph == 7) begin src_idle_on = 0; snk_idle_on = 0; end
            for (int k = 0; k < 210; k++)
                send_rand($urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 4));
            wait_drained();
        end

        $display("Covered %0d result words, %0d with lever-arm correction,",
                 sb.checked, sb.applied_cnt);
        $display("over reset, extreme and random matrix, lever and limit settings.");
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Timeout with %0d words outstanding", sb.pending.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
